// ----- sv/text_terminal_command_engine_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Text terminal command engine: assertion macros
// Property shorthands shared by the checker; clocked on aclk, off in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_COMMAND_ENGINE_UNIT_ASSERT_SVH
`define TEXT_TERMINAL_COMMAND_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define TTCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ttce assertion failed");

// next-cycle implication
`define TTCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ttce assertion failed");

`endif

// ----- sv/ttce_pkg.sv -----
// ----------------------------------------------------------------------------
// ttce_pkg
// Types, byte codes and shared constants of the text terminal command engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ttce_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 24;
    localparam int ROW_W       = 7;
    localparam int COL_W       = 7;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] ARG_END    = 8'h70;
    localparam logic [7:0] REPLY_LEAD = 8'hDD;
    localparam logic [7:0] REPLY_TAIL = 8'hDE;

    localparam logic [7:0] HB_BS      = 8'h08;
    localparam logic [7:0] HB_LF      = 8'h0A;
    localparam logic [7:0] HB_VT      = 8'h0B;
    localparam logic [7:0] HB_FF      = 8'h0C;
    localparam logic [7:0] HB_CR      = 8'h0D;
    localparam logic [7:0] HB_HOME    = 8'hC0;
    localparam logic [7:0] HB_UP      = 8'hC1;
    localparam logic [7:0] HB_DOWN    = 8'hC2;
    localparam logic [7:0] HB_LEFT    = 8'hC3;
    localparam logic [7:0] HB_RIGHT   = 8'hC4;
    localparam logic [7:0] HB_LOAD    = 8'hC5;
    localparam logic [7:0] HB_RDCUR   = 8'hC6;
    localparam logic [7:0] HB_PAGE    = 8'hC7;
    localparam logic [7:0] HB_SCROLL  = 8'hC8;
    localparam logic [7:0] HB_SET_TOP = 8'hC9;
    localparam logic [7:0] HB_SET_BOT = 8'hCA;
    localparam logic [7:0] HB_SET_LFT = 8'hCB;
    localparam logic [7:0] HB_SET_RGT = 8'hCC;
    localparam logic [7:0] HB_PROTECT = 8'hCD;
    localparam logic [7:0] HB_WR_ABS  = 8'hCE;
    localparam logic [7:0] HB_SKIP_A  = 8'hCF;
    localparam logic [7:0] HB_SKIP_B  = 8'hD0;
    localparam logic [7:0] HB_SKIP_C  = 8'hDC;
    localparam logic [7:0] HB_INS_LN  = 8'hD6;
    localparam logic [7:0] HB_DEL_LN  = 8'hD7;
    localparam logic [7:0] HB_CLEAR   = 8'hD8;
    localparam logic [7:0] HB_RESET   = 8'hF1;

    localparam logic [1:0] REPLY_LAST = 2'd3;

    typedef enum logic [1:0] {
        MODE_SCROLL,
        MODE_PAGE,
        MODE_PROTECT
    } mode_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_LOAD1, PH_LOAD2, PH_TOP, PH_BOTTOM, PH_LEFT, PH_RIGHT,
        PH_WA1, PH_WA2, PH_WA3, PH_WA4, PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_REPLY, ACT_CELL, ACT_DEL, ACT_INS, ACT_CLEAR, ACT_FILL
    } act_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_EXEC, OP_INIT, OP_SW_BLANK, OP_SW_READ, OP_SW_COPY, OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_EXEC, ST_SWEEP, ST_SWEEP_WR, ST_REPLY, ST_CELL
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        act_t act;
        logic sw_copy;
        logic sw_done;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic       command;
        logic [7:0] host_byte;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic [4:0] cursor_row_now;
        logic [6:0] cursor_col_now;
        logic [1:0] mode_now;
    } out_item_t;

endpackage

`default_nettype wire

// ----- sv/ttce_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttce_ctrl
// Sequencer: accepts a transaction, runs the step, line sweeps and replies.
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_ctrl
    import ttce_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    ctrl_state_t state_reg, state_next;
    logic [1:0]  k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        s_ready    = 1'b0;
        cmd.op     = OP_NONE;
        cmd.idx    = 2'd0;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                // clearing pass of the cell store
                cmd.op     = OP_INIT;
                state_next = ST_SWEEP;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.op = OP_EXEC;
                unique case (status.act)
                    ACT_NONE:  state_next = ST_IDLE;
                    ACT_REPLY: begin
                        k_next     = 2'd0;
                        state_next = ST_REPLY;
                    end
                    ACT_CELL:  state_next = ST_CELL;
                    default:   state_next = ST_SWEEP;
                endcase
            end
            ST_SWEEP: begin
                if (status.sw_copy) begin
                    cmd.op     = OP_SW_READ;
                    state_next = ST_SWEEP_WR;
                end else begin
                    cmd.op = OP_SW_BLANK;
                    if (status.sw_done) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP_WR: begin
                cmd.op     = OP_SW_COPY;
                state_next = status.sw_done ? ST_IDLE : ST_SWEEP;
            end
            ST_REPLY: begin
                if (status.out_free) begin
                    cmd.op   = OP_EMIT;
                    cmd.idx  = k_reg;
                    cmd.last = (k_reg == REPLY_LAST);
                    if (k_reg == REPLY_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_CELL: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/ttce_datapath.sv -----
// ----------------------------------------------------------------------------
// ttce_datapath
// Cursor, window, mode and parse registers, the cell store and its line
// sweep counters, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_datapath
    import ttce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire         aclk,
    input  wire         aresetn,
    input  in_item_t    s_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  wire         m_ready,
    output logic        m_valid,
    output out_item_t   m_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  ROWS_R = ROW_W'(ROWS);
    localparam logic [COL_W-1:0]  COLS_C = COL_W'(COLUMNS);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] y,
                                                    input logic [COL_W-1:0] x);
        return ADDR_W'(y) * COLS_A + ADDR_W'(x);
    endfunction

    in_item_t            item_reg;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COL_W-1:0]    wl_reg, wl_next, wr_reg, wr_next;
    logic [ROW_W-1:0]    wt_reg, wt_next, wb_reg, wb_next;
    mode_t               mode_reg, mode_next;
    phase_t              phase_reg, phase_next;
    logic [ROW_W-1:0]    prow_reg, prow_next;
    logic [COL_W-1:0]    pcol_reg, pcol_next;

    // line sweep
    logic [ROW_W-1:0]    sy_reg, send_reg;
    logic [COL_W-1:0]    sx_reg, sxl_reg, sxr_reg;
    logic                sdown_reg, scopy_reg;

    logic [7:0]          mem [CELLS];
    logic [7:0]          q_reg;

    logic                out_valid_reg;
    out_item_t           out_reg;

    // step decode
    logic [7:0]          c, v8;
    logic [COL_W-1:0]    v;
    logic                arg_ok, protect, page, at_bottom;
    logic [ROW_W:0]      row_p1;
    logic [COL_W:0]      col_p1;
    logic [ROW_W-1:0]    up_row, down_row, first;
    act_t                act;
    logic                ex_we;
    logic [ADDR_W-1:0]   ex_wa;

    // memory port
    logic                we, re, rd_off;
    logic [ADDR_W-1:0]   wa, ra, dst_a, src_a;
    logic [7:0]          wd;
    logic [ROW_W-1:0]    src_row;
    logic                sx_last;
    logic [7:0]          emit_data;

    assign c       = item_reg.host_byte;
    assign v8      = c - CH_SPACE;
    assign v       = v8[COL_W-1:0];
    assign arg_ok  = (c >= CH_SPACE) && (c < ARG_END);
    assign protect = (mode_reg == MODE_PROTECT);
    assign page    = (mode_reg == MODE_PAGE);
    assign row_p1  = {1'b0, row_reg} + 1'b1;
    assign col_p1  = {1'b0, col_reg} + 1'b1;
    assign at_bottom = (row_p1 == {1'b0, wb_reg});
    assign up_row  = (row_reg != wt_reg) ? row_reg - 1'b1 :
                     (page ? wb_reg - 1'b1 : row_reg);
    assign down_row = !at_bottom ? row_p1[ROW_W-1:0] : (page ? wt_reg : row_reg);

    always_comb begin
        row_next   = row_reg;
        col_next   = col_reg;
        wl_next    = wl_reg;
        wr_next    = wr_reg;
        wt_next    = wt_reg;
        wb_next    = wb_reg;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        prow_next  = prow_reg;
        pcol_next  = pcol_reg;
        act        = ACT_NONE;
        first      = row_reg;
        ex_we      = 1'b0;
        ex_wa      = cell_addr(row_reg, col_reg);
        if (item_reg.command) begin
            act = ACT_CELL;
        end else if (phase_reg == PH_IDLE) begin
            unique case (c)
                HB_BS, HB_LEFT: begin
                    if (!protect) begin
                        if (col_reg != wl_reg && col_reg != '0) begin
                            col_next = col_reg - 1'b1;
                        end else if (page) begin
                            col_next = wr_reg - 1'b1;
                            row_next = up_row;
                        end
                    end
                end
                HB_LF, HB_DOWN: begin
                    if (!protect) begin
                        row_next = down_row;
                        if (at_bottom && !page) begin
                            // scroll: drop the top window line
                            act   = ACT_DEL;
                            first = wt_reg;
                        end
                    end
                end
                HB_VT, HB_UP: begin
                    if (!protect) begin
                        row_next = up_row;
                    end
                end
                HB_FF, HB_RIGHT: begin
                    if (!protect) begin
                        if (col_p1 < {1'b0, wr_reg}) begin
                            col_next = col_p1[COL_W-1:0];
                        end else if (page) begin
                            col_next = '0;
                            row_next = down_row;
                        end
                    end
                end
                HB_CR:   col_next = wl_reg;
                HB_HOME: begin
                    col_next = wl_reg;
                    row_next = wt_reg;
                end
                HB_LOAD:  phase_next = PH_LOAD1;
                HB_RDCUR: act = ACT_REPLY;
                HB_PAGE, HB_SCROLL, HB_PROTECT: begin
                    if (c == HB_PROTECT || (c == HB_PAGE && !page) ||
                        (c == HB_SCROLL && mode_reg != MODE_SCROLL)) begin
                        mode_next = (c == HB_PROTECT) ? MODE_PROTECT :
                                    (c == HB_PAGE) ? MODE_PAGE : MODE_SCROLL;
                        wl_next  = '0;
                        wr_next  = COLS_C;
                        wt_next  = '0;
                        wb_next  = ROWS_R;
                        row_next = '0;
                        col_next = '0;
                    end
                end
                HB_SET_TOP: phase_next = PH_TOP;
                HB_SET_BOT: phase_next = PH_BOTTOM;
                HB_SET_LFT: phase_next = PH_LEFT;
                HB_SET_RGT: phase_next = PH_RIGHT;
                HB_WR_ABS:  phase_next = PH_WA1;
                HB_SKIP_A, HB_SKIP_B, HB_SKIP_C: phase_next = PH_SKIP;
                HB_INS_LN: begin
                    if (page) begin
                        act      = ACT_INS;
                        col_next = wl_reg;
                    end
                end
                HB_DEL_LN: begin
                    if (page) begin
                        act      = ACT_DEL;
                        col_next = wl_reg;
                    end
                end
                HB_CLEAR: begin
                    act      = ACT_CLEAR;
                    col_next = wl_reg;
                    row_next = wt_reg;
                end
                HB_RESET: begin
                    act       = ACT_FILL;
                    mode_next = MODE_SCROLL;
                    wl_next   = '0;
                    wr_next   = COLS_C;
                    wt_next   = '0;
                    wb_next   = ROWS_R;
                    row_next  = '0;
                    col_next  = '0;
                end
                default: begin
                    if (c >= CH_SPACE && c <= CH_TILDE && !protect) begin
                        ex_we = (row_reg < ROWS_R) && (col_reg < COLS_C);
                        if (col_p1 >= {1'b0, wr_reg}) begin
                            if (!page) begin
                                col_next = wr_reg - 1'b1;
                            end else begin
                                col_next = wl_reg;
                                row_next = (row_p1 >= {1'b0, wb_reg}) ? wt_reg :
                                           row_p1[ROW_W-1:0];
                            end
                        end else begin
                            col_next = col_p1[COL_W-1:0];
                        end
                    end
                end
            endcase
        end else begin
            phase_next = PH_IDLE;
            unique case (phase_reg)
                PH_LOAD1: begin
                    if (arg_ok) begin
                        prow_next  = v;
                        phase_next = PH_LOAD2;
                    end
                end
                PH_LOAD2: begin
                    if (arg_ok && prow_reg >= wt_reg && prow_reg < wb_reg &&
                        v >= wl_reg && v < wr_reg) begin
                        row_next = prow_reg;
                        col_next = v;
                    end
                end
                PH_TOP: begin
                    if (arg_ok && v < wb_reg) begin
                        wt_next = v;
                        if (row_reg < v) begin
                            row_next = v;
                        end
                    end
                end
                PH_BOTTOM: begin
                    if (arg_ok && v > wt_reg && v < ROWS_R) begin
                        wb_next = v + 1'b1;
                        if (row_reg > v) begin
                            row_next = v;
                        end
                    end
                end
                PH_LEFT: begin
                    if (arg_ok && v < wr_reg) begin
                        wl_next = v;
                        if (col_reg < v) begin
                            col_next = v;
                        end
                    end
                end
                PH_RIGHT: begin
                    if (arg_ok && v > wl_reg && v < COLS_C) begin
                        wr_next = v + 1'b1;
                        if (col_reg > v) begin
                            col_next = v;
                        end
                    end
                end
                PH_WA1: begin
                    if (c == REPLY_LEAD) begin
                        phase_next = PH_WA2;
                    end
                end
                PH_WA2: begin
                    if (arg_ok) begin
                        prow_next  = v;
                        phase_next = PH_WA3;
                    end
                end
                PH_WA3: begin
                    if (arg_ok) begin
                        pcol_next  = v;
                        phase_next = PH_WA4;
                    end
                end
                PH_WA4: begin
                    ex_wa = cell_addr(prow_reg, pcol_reg);
                    if (c >= CH_SPACE && c < CH_DEL && prow_reg < ROWS_R &&
                        pcol_reg < COLS_C) begin
                        ex_we      = 1'b1;
                        pcol_next  = pcol_reg + 1'b1;
                        phase_next = PH_WA4;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sweep addressing
    assign src_row = sdown_reg ? sy_reg - 1'b1 : sy_reg + 1'b1;
    assign dst_a   = cell_addr(sy_reg, sx_reg);
    assign src_a   = cell_addr(src_row, sx_reg);
    assign sx_last = ({1'b0, sx_reg} + 1'b1) == {1'b0, sxr_reg};

    assign rd_off = (ROW_W'(item_reg.read_row) >= ROWS_R) ||
                    (item_reg.read_col >= COLS_C);

    always_comb begin
        we = 1'b0;
        wa = dst_a;
        wd = CH_SPACE;
        re = 1'b0;
        ra = cell_addr(ROW_W'(item_reg.read_row), item_reg.read_col);
        unique case (cmd.op)
            OP_EXEC: begin
                we = ex_we;
                wa = ex_wa;
                wd = c;
                re = item_reg.command && !rd_off;
            end
            OP_SW_BLANK: we = 1'b1;
            OP_SW_COPY: begin
                we = 1'b1;
                wd = q_reg;
            end
            OP_SW_READ: begin
                re = 1'b1;
                ra = src_a;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            q_reg <= mem[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            wl_reg    <= '0;
            wr_reg    <= COLS_C;
            wt_reg    <= '0;
            wb_reg    <= ROWS_R;
            mode_reg  <= MODE_SCROLL;
            phase_reg <= PH_IDLE;
            prow_reg  <= '0;
            pcol_reg  <= '0;
        end else if (cmd.op == OP_EXEC) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            wl_reg    <= wl_next;
            wr_reg    <= wr_next;
            wt_reg    <= wt_next;
            wb_reg    <= wb_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            prow_reg  <= prow_next;
            pcol_reg  <= pcol_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            item_reg <= s_data;
        end
        if (cmd.op == OP_INIT || (cmd.op == OP_EXEC && act == ACT_FILL)) begin
            sy_reg    <= '0;
            send_reg  <= ROWS_R - 1'b1;
            sdown_reg <= 1'b0;
            scopy_reg <= 1'b0;
            sx_reg    <= '0;
            sxl_reg   <= '0;
            sxr_reg   <= COLS_C;
        end else if (cmd.op == OP_EXEC) begin
            sx_reg  <= wl_reg;
            sxl_reg <= wl_reg;
            sxr_reg <= wr_reg;
            unique case (act)
                ACT_DEL: begin
                    sy_reg    <= first;
                    send_reg  <= wb_reg - 1'b1;
                    sdown_reg <= 1'b0;
                    scopy_reg <= 1'b1;
                end
                ACT_INS: begin
                    sy_reg    <= wb_reg - 1'b1;
                    send_reg  <= first;
                    sdown_reg <= 1'b1;
                    scopy_reg <= 1'b1;
                end
                default: begin
                    sy_reg    <= wt_reg;
                    send_reg  <= wb_reg - 1'b1;
                    sdown_reg <= 1'b0;
                    scopy_reg <= 1'b0;
                end
            endcase
        end else if (cmd.op == OP_SW_BLANK || cmd.op == OP_SW_COPY) begin
            if (sx_last) begin
                sx_reg <= sxl_reg;
                sy_reg <= sdown_reg ? sy_reg - 1'b1 : sy_reg + 1'b1;
            end else begin
                sx_reg <= sx_reg + 1'b1;
            end
        end
    end

    // result register
    always_comb begin
        if (item_reg.command) begin
            emit_data = rd_off ? 8'h00 : q_reg;
        end else begin
            unique case (cmd.idx)
                2'd0:    emit_data = REPLY_LEAD;
                2'd1:    emit_data = 8'(row_reg) + CH_SPACE;
                2'd2:    emit_data = 8'(col_reg) + CH_SPACE;
                default: emit_data = REPLY_TAIL;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_reg.kind           <= item_reg.command;
            out_reg.data           <= emit_data;
            out_reg.last           <= cmd.last;
            out_reg.cursor_row_now <= 5'(row_reg);
            out_reg.cursor_col_now <= col_reg;
            out_reg.mode_now       <= mode_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;
    assign status.act      = act;
    assign status.sw_copy  = scopy_reg && (sy_reg != send_reg);
    assign status.sw_done  = sx_last && (sy_reg == send_reg);
    assign status.out_free = !out_valid_reg || m_ready;

endmodule

`default_nettype wire

// ----- sv/text_terminal_command_engine_unit.sv -----
// ----------------------------------------------------------------------------
// text_terminal_command_engine_unit
// Command engine of a character-cell display terminal.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction is either a host byte (command 0) or a
// read of one screen cell (command 1). Result channel m_*: read cursor gives
// four reply bytes, a cell read gives one cell result; other bytes give none.
// A host byte is taken in the idle state and executed in the execute state
// before the next byte is taken. Read cursor then emits four reply bytes, each
// once the output register is free; a cell read emits one result (the store
// is read in the execute cycle). Line insert and delete walk the window rows
// in the cell store, which has one read and one write port: a copied cell is
// read in the sweep state and written in the sweep-write state, a blanked one
// in the sweep state. Clear window blanks every window cell, full reset (0xF1)
// every screen cell, ROWS*COLUMNS in all. After reset the same clearing pass
// fills the store with spaces; s_ready stays low until it is done.
// The result sits in an output register; when m_ready is low the engine
// still takes a new input transaction and holds its next result until the
// register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_command_engine_unit
    import ttce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  wire        m_ready,
    output out_item_t  m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ttce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ttce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- sv/ttce_checker.sv -----
// ----------------------------------------------------------------------------
// ttce_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_terminal_command_engine_unit_assert.svh"

module ttce_checker
    import ttce_pkg::*;
(
    input wire       aclk,
    input wire       aresetn,
    input wire       m_valid,
    input wire       m_ready,
    input out_item_t m_data
);

    // stalled transaction holds
    `TTCE_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // a cell read is always a single result
    `TTCE_ASSERT_IMP(a_cell_last, m_valid && m_data.kind, m_data.last)
    // reply run ends with the trailer byte
    `TTCE_ASSERT_IMP(a_reply_tail, m_valid && !m_data.kind && m_data.last,
                     m_data.data == REPLY_TAIL)
    `TTCE_ASSERT_IMP(a_mode_code, m_valid, m_data.mode_now != 2'd3)

endmodule

bind text_terminal_command_engine_unit ttce_checker u_ttce_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Text terminal command engine testbench
// Drives host bytes and cell reads through the input channel. It predicts
// cursor, window, mode and screen contents, and checks every reply and
// cell result field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ttce_pkg::*;

    localparam int NCOL = DEF_COLUMNS;
    localparam int NROW = DEF_ROWS;
    localparam int STALL_LIMIT = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    text_terminal_command_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // terminal state as predicted
    logic [7:0] screen [NROW*NCOL];
    int     cur_row, cur_col, win_left, win_right, win_top, win_bot;
    mode_t  term_mode;
    phase_t seq_phase;
    int     seq_row, seq_col;

    out_item_t expected_results [$];
    int  fail_count;
    int  send_idle_pct, recv_idle_pct;
    int  quiet_cycles;
    bit  timed_out;

    task automatic report(input string what, input out_item_t got, input out_item_t want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic [7:0] cell_at(input int r, input int c);
        if (r < NROW && c < NCOL)
            return screen[r*NCOL+c];
        return 8'h00;
    endfunction

    function automatic void cell_put(input int r, input int c, input logic [7:0] v);
        if (r < NROW && c < NCOL)
            screen[r*NCOL+c] = v;
    endfunction

    function automatic void blank_line(input int r);
        for (int c = win_left; c < win_right; c++)
            cell_put(r, c, CH_SPACE);
    endfunction

    function automatic void drop_line(input int first);
        for (int r = first + 1; r < win_bot; r++)
            for (int c = win_left; c < win_right; c++)
                cell_put(r - 1, c, cell_at(r, c));
        blank_line(win_bot - 1);
    endfunction

    function automatic void open_line(input int first);
        for (int r = win_bot - 1; r > first; r--)
            for (int c = win_left; c < win_right; c++)
                cell_put(r, c, cell_at(r - 1, c));
        blank_line(first);
    endfunction

    function automatic void go_home();
        cur_col = win_left;
        cur_row = win_top;
    endfunction

    function automatic void full_window();
        win_left = 0;
        win_right = NCOL;
        win_top = 0;
        win_bot = NROW;
    endfunction

    function automatic void screen_reset();
        for (int i = 0; i < NROW*NCOL; i++)
            screen[i] = CH_SPACE;
        full_window();
        term_mode = MODE_SCROLL;
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic void cursor_up();
        if (term_mode == MODE_PROTECT)
            return;
        if (cur_row != win_top)
            cur_row--;
        else if (term_mode == MODE_PAGE)
            cur_row = win_bot - 1;
    endfunction

    function automatic void cursor_down();
        if (term_mode == MODE_PROTECT)
            return;
        if (cur_row + 1 != win_bot)
            cur_row++;
        else if (term_mode == MODE_PAGE)
            cur_row = win_top;
        else
            drop_line(win_top);
    endfunction

    function automatic void cursor_left();
        if (term_mode == MODE_PROTECT)
            return;
        if (cur_col != win_left && cur_col != 0) begin
            cur_col--;
        end else if (term_mode == MODE_PAGE) begin
            cur_col = win_right - 1;
            cursor_up();
        end
    endfunction

    function automatic void cursor_right();
        if (term_mode == MODE_PROTECT)
            return;
        if (cur_col + 1 < win_right) begin
            cur_col++;
        end else if (term_mode == MODE_PAGE) begin
            cur_col = 0;
            cursor_down();
        end
    endfunction

    function automatic void type_char(input logic [7:0] ch);
        if (term_mode == MODE_PROTECT)
            return;
        cell_put(cur_row, cur_col, ch);
        cur_col++;
        if (cur_col >= win_right) begin
            if (term_mode == MODE_SCROLL) begin
                cur_col = win_right - 1;
            end else begin
                cur_col = win_left;
                cur_row++;
                if (cur_row >= win_bot)
                    cur_row = win_top;
            end
        end
    endfunction

    function automatic void switch_mode(input mode_t m, input bit always_do);
        if (always_do || term_mode != m) begin
            term_mode = m;
            full_window();
            go_home();
        end
    endfunction

    function automatic out_item_t make_result(input logic k, input logic [7:0] d,
                                              input logic l);
        out_item_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        r.cursor_row_now = cur_row[4:0];
        r.cursor_col_now = cur_col[6:0];
        r.mode_now = term_mode;
        return r;
    endfunction

    // advances the predicted terminal by one accepted transaction
    function automatic void predict_terminal(input in_item_t it);
        logic [7:0] b;
        bit ok;
        int v;
        phase_t ph;
        b = it.host_byte;
        ok = (b >= CH_SPACE && b < ARG_END);
        v = int'(b) - 32;
        if (it.command) begin
            expected_results.push_back(make_result(1'b1,
                cell_at(it.read_row, it.read_col), 1'b1));
            return;
        end
        ph = seq_phase;
        if (ph != PH_IDLE) begin
            seq_phase = PH_IDLE;
            case (ph)
                PH_LOAD1: if (ok) begin
                    seq_row = v;
                    seq_phase = PH_LOAD2;
                end
                PH_LOAD2: if (ok && seq_row >= win_top && seq_row < win_bot &&
                              v >= win_left && v < win_right) begin
                    cur_row = seq_row;
                    cur_col = v;
                end
                PH_TOP: if (ok && v < win_bot) begin
                    win_top = v;
                    if (cur_row < win_top) cur_row = win_top;
                end
                PH_BOTTOM: if (ok && v > win_top && v < NROW) begin
                    win_bot = v + 1;
                    if (cur_row >= win_bot) cur_row = win_bot - 1;
                end
                PH_LEFT: if (ok && v < win_right) begin
                    win_left = v;
                    if (cur_col < win_left) cur_col = win_left;
                end
                PH_RIGHT: if (ok && v > win_left && v < NCOL) begin
                    win_right = v + 1;
                    if (cur_col >= win_right) cur_col = win_right - 1;
                end
                PH_WA1: if (b == REPLY_LEAD) seq_phase = PH_WA2;
                PH_WA2: if (ok) begin
                    seq_row = v;
                    seq_phase = PH_WA3;
                end
                PH_WA3: if (ok) begin
                    seq_col = v;
                    seq_phase = PH_WA4;
                end
                PH_WA4: if (b >= CH_SPACE && b < CH_DEL && seq_row < NROW &&
                            seq_col < NCOL) begin
                    cell_put(seq_row, seq_col, b);
                    seq_col++;
                    seq_phase = PH_WA4;
                end
                default: ;
            endcase
            return;
        end
        case (b)
            HB_BS, HB_LEFT:   cursor_left();
            HB_LF, HB_DOWN:   cursor_down();
            HB_VT, HB_UP:     cursor_up();
            HB_FF, HB_RIGHT:  cursor_right();
            HB_CR:            cur_col = win_left;
            HB_HOME:          go_home();
            HB_LOAD:          seq_phase = PH_LOAD1;
            HB_RDCUR: begin
                expected_results.push_back(make_result(1'b0, REPLY_LEAD, 1'b0));
                expected_results.push_back(make_result(1'b0, 8'(32 + cur_row), 1'b0));
                expected_results.push_back(make_result(1'b0, 8'(32 + cur_col), 1'b0));
                expected_results.push_back(make_result(1'b0, REPLY_TAIL, 1'b1));
            end
            HB_PAGE:          switch_mode(MODE_PAGE, 1'b0);
            HB_SCROLL:        switch_mode(MODE_SCROLL, 1'b0);
            HB_SET_TOP:       seq_phase = PH_TOP;
            HB_SET_BOT:       seq_phase = PH_BOTTOM;
            HB_SET_LFT:       seq_phase = PH_LEFT;
            HB_SET_RGT:       seq_phase = PH_RIGHT;
            HB_PROTECT:       switch_mode(MODE_PROTECT, 1'b1);
            HB_WR_ABS:        seq_phase = PH_WA1;
            HB_SKIP_A, HB_SKIP_B, HB_SKIP_C: seq_phase = PH_SKIP;
            HB_INS_LN: if (term_mode == MODE_PAGE) begin
                open_line(cur_row);
                cur_col = win_left;
            end
            HB_DEL_LN: if (term_mode == MODE_PAGE) begin
                drop_line(cur_row);
                cur_col = win_left;
            end
            HB_CLEAR: begin
                for (int r = win_top; r < win_bot; r++)
                    blank_line(r);
                go_home();
            end
            HB_RESET:         screen_reset();
            default: if (b >= CH_SPACE && b <= CH_TILDE) type_char(b);
        endcase
    endfunction

    // result checker, watchdog and receiver idling
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected", m_data, '0);
                end else begin
                    out_item_t w;
                    w = expected_results.pop_front();
                    if (m_data.kind !== w.kind) report("kind", m_data, w);
                    if (m_data.data !== w.data) report("data", m_data, w);
                    if (m_data.last !== w.last) report("last", m_data, w);
                    if (m_data.cursor_row_now !== w.cursor_row_now) report("row", m_data, w);
                    if (m_data.cursor_col_now !== w.cursor_col_now) report("col", m_data, w);
                    if (m_data.mode_now !== w.mode_now) report("mode", m_data, w);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end
    end

    // valid drops only for an idle gap, so back-to-back items get one assignment
    task automatic send_item(input in_item_t it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_terminal(it);
    endtask

    function automatic in_item_t host(input logic [7:0] b);
        in_item_t it;
        it = '0;
        it.host_byte = b;
        it.read_row = 5'($urandom);
        it.read_col = 7'($urandom);
        return it;
    endfunction

    function automatic in_item_t cell_read(input int r, input int c);
        in_item_t it;
        it = '0;
        it.command = 1'b1;
        it.host_byte = 8'($urandom);
        it.read_row = 5'(r);
        it.read_col = 7'(c);
        return it;
    endfunction

    function automatic logic [7:0] arg(input int v);
        return 8'(32 + v);
    endfunction

    function automatic logic [7:0] random_command();
        case ($urandom_range(21))
            0: return HB_BS;    1: return HB_LF;    2: return HB_VT;
            3: return HB_FF;    4: return HB_CR;    5: return HB_HOME;
            6: return HB_UP;    7: return HB_DOWN;  8: return HB_LEFT;
            9: return HB_RIGHT; 10: return HB_RDCUR; 11: return HB_PAGE;
            12: return HB_SCROLL; 13: return HB_INS_LN; 14: return HB_DEL_LN;
            15: return HB_CLEAR; 16: return HB_PROTECT;
            17: return (($urandom_range(19) == 0) ? HB_RESET : HB_HOME);
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    // one random well-formed sequence, a cell read or a noise byte
    task automatic random_burst();
        int sel;
        int n;
        sel = $urandom_range(15);
        case (sel)
            0: begin
                send_item(host(HB_LOAD));
                send_item(host(arg($urandom_range(NROW))));
                send_item(host(arg($urandom_range(NCOL))));
            end
            1: begin
                send_item(host(HB_SET_TOP + 8'($urandom_range(3))));
                send_item(host(arg($urandom_range(NCOL - 1))));
            end
            2: begin
                send_item(host(HB_WR_ABS));
                send_item(host($urandom_range(9) == 0 ? 8'($urandom) : REPLY_LEAD));
                send_item(host(arg($urandom_range(NROW))));
                send_item(host(arg($urandom_range(NCOL - 1))));
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_item(host(8'($urandom_range(32, 126))));
                send_item(host(8'($urandom)));
            end
            3: begin
                send_item(host(HB_SKIP_A));
                send_item(host(8'($urandom)));
            end
            4: send_item(host(8'($urandom)));
            5, 6: send_item(cell_read($urandom_range(31), $urandom_range(127)));
            7: send_item(cell_read(cur_row, cur_col));
            default: send_item(host(random_command()));
        endcase
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out) @(posedge aclk);
        repeat (NROW*NCOL + 100) @(posedge aclk);
    endtask

    typedef struct {
        in_item_t  stim;
        bit        check_fixed;
        out_item_t fixed;
    } directed_row_t;

    initial begin
        directed_row_t plan [$];
        directed_row_t row;
        out_item_t     want;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        fail_count = 0;
        timed_out = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 73;
        expected_results = {};
        screen_reset();
        seq_phase = PH_IDLE;
        seq_row = 0;
        seq_col = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // after reset: blank cell at the far corner, then off-screen reads
        want = '0;
        want.kind = 1'b1;
        want.data = CH_SPACE;
        want.last = 1'b1;
        row = '{cell_read(NROW - 1, NCOL - 1), 1'b1, want};
        plan.push_back(row);
        want.kind = 1'b0;
        want.data = 8'h00;
        row = '{cell_read(NROW, NCOL), 1'b0, want};
        plan.push_back(row);
        row = '{cell_read(31, 127), 1'b0, want};
        plan.push_back(row);
        begin
            logic [7:0] seq [$];
            seq = {HB_RDCUR, 8'h7E, 8'h20, HB_BS, HB_PAGE, HB_BS, HB_RDCUR,
                   HB_LOAD, arg(NROW - 1), arg(NCOL - 1), 8'h41, HB_RDCUR,
                   HB_INS_LN, HB_DEL_LN, HB_SET_LFT, 8'h70, HB_LOAD, 8'hFF,
                   HB_WR_ABS, REPLY_LEAD, arg(0), arg(NCOL - 2), 8'h5A, 8'h5B,
                   8'h5C, 8'h7F, HB_SCROLL, HB_LF, HB_PROTECT, 8'h61, HB_CLEAR,
                   HB_RESET, 8'hFF, 8'h00};
            foreach (seq[i]) begin
                row = '{host(seq[i]), 1'b0, want};
                plan.push_back(row);
            end
        end
        row = '{cell_read(0, NCOL - 2), 1'b0, want};
        plan.push_back(row);

        // only the far-corner read carries a fixed expectation; the rest use the predictor
        foreach (plan[i]) begin
            if (plan[i].check_fixed) begin
                send_item(plan[i].stim);
                if (expected_results.size() != 0 &&
                    expected_results[$] !== plan[i].fixed)
                    report("directed", expected_results[$], plan[i].fixed);
            end else begin
                send_item(plan[i].stim);
            end
        end

        for (int ph = 0; ph < 3 && !timed_out; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 73;
                recv_idle_pct = 35;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (76) if (!timed_out) random_burst();
        end
        settle();
        if (timed_out || expected_results.size() != 0 || fail_count != 0) begin
            $display("Test completed with failures");
        end else begin
            $display("Test completed successfully");
        end
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ttce_pkg.sv
sv/ttce_ctrl.sv
sv/ttce_datapath.sv
sv/text_terminal_command_engine_unit.sv
sv/ttce_checker.sv
tb/testbench.sv
